>>> rtl/core/slt_pkg.sv
`default_nettype none
package slt_pkg;
    localparam int unsigned TableEntriesDefault = 64;
    localparam logic [31:0] MaxAgeReset = 32'd10;
    localparam int unsigned EntryW = 64 + 64 + 16 + 16 + 32;

    typedef enum logic [1:0] {
        KIND_UPDATE = 2'd0,
        KIND_EXPIRE = 2'd1,
        KIND_LOOKUP = 2'd2,
        KIND_QUERY  = 2'd3
    } t_kind;

    typedef struct packed {
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [15:0] port;
        logic [15:0] load;
        logic [31:0] time_value;
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } t_state;
endpackage
`default_nettype wire

>>> rtl/core/slt_mem.sv
`default_nettype none
module slt_mem
    import slt_pkg::*;
#(
    parameter int unsigned DEPTH = TableEntriesDefault,
    localparam int unsigned AW = $clog2(DEPTH)
) (
    input  wire           i_clk,
    input  wire           i_we,
    input  wire  [AW-1:0] i_waddr,
    input  wire  t_entry  i_wdata,
    input  wire  [AW-1:0] i_raddr,
    output t_entry        o_rdata
);
    t_entry r_mem [DEPTH];

    // one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> rtl/core/server_load_table_unit.sv
// Server load table. One item is taken at a time and walks the entry memory
// one entry per cycle through its single read port. A full walk (expire,
// least-busy query, or a lookup or update that misses) reads every held
// entry before the result is loaded; a lookup or update that hits stops at
// the matching entry. An update writes in the same cycle the result is
// loaded. The next word is accepted once the unit is back in idle after the
// result is loaded. Expire compacts in place, reading entry i and writing
// survivor w behind it. The result is held in an output register until
// taken; a new word may be accepted meanwhile and waits before its own
// result while the old one is pending. The max_age register is written only
// when idle with no result pending.
`default_nettype none
module server_load_table_unit
    import slt_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = TableEntriesDefault,
    localparam int unsigned AW = $clog2(TABLE_ENTRIES),
    localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1)
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_valid,
    output logic         o_cfg_ready,
    input  wire  [31:0]  i_cfg_data,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // addr_high, addr_low, port, load, time_value
    input  wire  [191:0] s_axis_tdata,
    // kind
    input  wire  [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // found, out_addr_high, out_addr_low, out_port, out_load, out_time,
    // removed_any, status, entry_count, 6 zero bits
    output logic [207:0] m_axis_tdata
);
    t_state r_state, n_state;
    t_kind  r_kind;
    t_entry r_key;
    logic [CW-1:0] r_cnt, r_i, r_w, r_best;
    logic [31:0] r_max_age, r_cutoff;
    logic        r_hit, r_have;
    t_entry      r_res;
    logic [15:0] r_best_load;
    t_entry      rd;
    logic        r_rv;
    logic [CW-1:0] r_ri;
    logic        we;
    logic [AW-1:0] waddr, raddr;
    t_entry      wdata;
    logic        keq, keep;
    t_entry      in_entry;
    logic        res_wait;
    logic [CW-1:0] n_cnt;
    logic [207:0] n_tdata;

    slt_mem #(.DEPTH(TABLE_ENTRIES)) u_mem (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rd)
    );

    assign o_cfg_ready = (r_state == ST_IDLE) && !m_axis_tvalid;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign res_wait = m_axis_tvalid && !m_axis_tready;
    assign in_entry = {s_axis_tdata[63:0], s_axis_tdata[127:64], s_axis_tdata[143:128],
                       s_axis_tdata[159:144], s_axis_tdata[191:160]};
    assign raddr = r_i[AW-1:0];
    assign keq = (rd.addr_high == r_key.addr_high) && (rd.addr_low == r_key.addr_low)
                 && (rd.port == r_key.port);
    assign keep = !(rd.time_value < r_cutoff);

    // next state and memory write
    always_comb begin
        n_state = r_state;
        we = 1'b0;
        waddr = r_w[AW-1:0];
        wdata = rd;
        unique case (r_state)
            ST_IDLE: if (s_axis_tvalid && s_axis_tready) n_state = ST_SCAN;
            ST_SCAN: begin
                if (r_rv && r_kind == KIND_EXPIRE && keep) we = 1'b1;
                if (!r_rv && r_i >= r_cnt) n_state = ST_WRITE;
                else if (r_rv && keq && (r_kind == KIND_UPDATE || r_kind == KIND_LOOKUP))
                    n_state = ST_WRITE;
            end
            ST_WRITE: begin
                // wait here while the previous result is still pending
                if (!res_wait) begin
                    n_state = ST_DONE;
                    if (r_kind == KIND_UPDATE && (r_hit || r_cnt < CW'(TABLE_ENTRIES))) begin
                        we = 1'b1;
                        waddr = r_hit ? r_best[AW-1:0] : r_cnt[AW-1:0];
                        wdata = r_key;
                        if (r_hit) begin
                            wdata.addr_high = r_res.addr_high;
                            wdata.addr_low = r_res.addr_low;
                            wdata.port = r_res.port;
                        end
                    end
                end
            end
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // result word and count after the item
    always_comb begin
        n_tdata = '0;
        n_cnt = r_cnt;
        unique case (r_kind)
            KIND_UPDATE: begin
                if (!r_hit && r_cnt < CW'(TABLE_ENTRIES)) n_cnt = r_cnt + 1'b1;
                n_tdata[194] = !r_hit && (r_cnt >= CW'(TABLE_ENTRIES));
            end
            KIND_EXPIRE: begin
                n_cnt = r_w;
                n_tdata[193] = (r_w != r_cnt);
            end
            default: begin
                if (r_hit || r_have) begin
                    n_tdata[0] = 1'b1;
                    n_tdata[64:1] = r_res.addr_high;
                    n_tdata[128:65] = r_res.addr_low;
                    n_tdata[144:129] = r_res.port;
                    n_tdata[160:145] = r_res.load;
                    n_tdata[192:161] = r_res.time_value;
                end
            end
        endcase
        n_tdata[201:195] = 7'(n_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt <= '0;
            r_max_age <= MaxAgeReset;
            m_axis_tvalid <= 1'b0;
            r_rv <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) r_max_age <= i_cfg_data;
            // result register: load when the item finishes, clear when taken
            if (r_state == ST_WRITE && !res_wait) begin
                m_axis_tvalid <= 1'b1;
                m_axis_tdata <= n_tdata;
                r_cnt <= n_cnt;
            end else if (m_axis_tvalid && m_axis_tready) begin
                m_axis_tvalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    r_rv <= 1'b0;
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_kind <= t_kind'(s_axis_tuser);
                        r_key <= in_entry;
                        r_cutoff <= (in_entry.time_value > r_max_age) ?
                                    in_entry.time_value - r_max_age : 32'd0;
                        r_i <= '0;
                        r_w <= '0;
                        r_hit <= 1'b0;
                        r_have <= 1'b0;
                    end
                end
                ST_SCAN: begin
                    // issue next read while the current entry is checked
                    r_rv <= (r_i < r_cnt) && !(r_rv && keq &&
                            (r_kind == KIND_UPDATE || r_kind == KIND_LOOKUP));
                    r_ri <= r_i;
                    if (r_i < r_cnt) r_i <= r_i + 1'b1;
                    if (r_rv) begin
                        if (r_kind == KIND_EXPIRE && keep) r_w <= r_w + 1'b1;
                        if (keq && (r_kind == KIND_UPDATE || r_kind == KIND_LOOKUP)) begin
                            r_hit <= 1'b1;
                            r_res <= rd;
                            r_best <= r_ri;
                        end
                        if (r_kind == KIND_QUERY && (!r_have || rd.load < r_best_load)) begin
                            r_have <= 1'b1;
                            r_res <= rd;
                            r_best_load <= rd.load;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // count bound, input gating and result hand-off
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(TABLE_ENTRIES)) else $error("count above depth");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !s_axis_tready) else $error("ready while busy");
    a_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRITE) |=> m_axis_tvalid) else $error("result lost");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while waiting");
endmodule
`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import slt_pkg::*;

    localparam int unsigned SLOTS = TableEntriesDefault;
    localparam int unsigned STALL_LIMIT = 20000;
    localparam int unsigned HOLD_CYCLES = 400;

    typedef struct packed {
        t_kind       kind;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [15:0] port;
        logic [15:0] load;
        logic [31:0] time_value;
    } t_request;

    typedef struct packed {
        logic        found;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [15:0] port;
        logic [15:0] load;
        logic [31:0] time_value;
        logic        removed_any;
        logic        status;
        logic [6:0]  entry_count;
    } t_answer;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [31:0]  i_cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // addr_high, addr_low, port, load, time_value
    logic [191:0] s_axis_tdata;
    // kind
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // found, out_addr_high, out_addr_low, out_port, out_load, out_time,
    // removed_any, status, entry_count, 6 zero bits
    logic [207:0] m_axis_tdata;

    server_load_table_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // shadow copy of the server table
    logic [63:0] tbl_ah [SLOTS];
    logic [63:0] tbl_al [SLOTS];
    logic [15:0] tbl_port [SLOTS];
    logic [15:0] tbl_load [SLOTS];
    logic [31:0] tbl_time [SLOTS];
    int unsigned tbl_count;
    logic [31:0] age_limit;

    t_request pending_words[$];
    t_answer  expected_answers[$];
    int unsigned mismatches;
    int unsigned accepted_items;
    int unsigned returned_answers;
    bit          calm;
    bit          hold_rx;
    bit          hold_taken;
    int unsigned hold_left;
    int unsigned tx_gap, rx_gap;

    function automatic int unsigned find_key(t_request r);
        for (int unsigned i = 0; i < tbl_count; i++)
            if (tbl_ah[i] == r.addr_high && tbl_al[i] == r.addr_low &&
                tbl_port[i] == r.port)
                return i;
        return tbl_count;
    endfunction

    function automatic t_answer fill_entry(int unsigned i);
        t_answer a;
        a = '0;
        a.found = 1'b1;
        a.addr_high = tbl_ah[i];
        a.addr_low = tbl_al[i];
        a.port = tbl_port[i];
        a.load = tbl_load[i];
        a.time_value = tbl_time[i];
        return a;
    endfunction

    // unpack the output word, lowest field first
    function automatic t_answer take_answer(logic [207:0] d);
        t_answer a;
        a.found = d[0];
        a.addr_high = d[64:1];
        a.addr_low = d[128:65];
        a.port = d[144:129];
        a.load = d[160:145];
        a.time_value = d[192:161];
        a.removed_any = d[193];
        a.status = d[194];
        a.entry_count = d[201:195];
        return a;
    endfunction

    // apply one request to the shadow table and return the answer
    function automatic t_answer serve_request(t_request r);
        t_answer a;
        int unsigned idx, w, best;
        logic [31:0] cutoff;
        a = '0;
        case (r.kind)
            KIND_UPDATE: begin
                idx = find_key(r);
                if (idx < tbl_count) begin
                    tbl_load[idx] = r.load;
                    tbl_time[idx] = r.time_value;
                end else if (tbl_count < SLOTS) begin
                    tbl_ah[tbl_count] = r.addr_high;
                    tbl_al[tbl_count] = r.addr_low;
                    tbl_port[tbl_count] = r.port;
                    tbl_load[tbl_count] = r.load;
                    tbl_time[tbl_count] = r.time_value;
                    tbl_count++;
                end else begin
                    a.status = 1'b1;
                end
            end
            KIND_EXPIRE: begin
                cutoff = (r.time_value > age_limit) ? r.time_value - age_limit : 32'd0;
                w = 0;
                for (int unsigned i = 0; i < tbl_count; i++) begin
                    if (tbl_time[i] >= cutoff) begin
                        tbl_ah[w] = tbl_ah[i];
                        tbl_al[w] = tbl_al[i];
                        tbl_port[w] = tbl_port[i];
                        tbl_load[w] = tbl_load[i];
                        tbl_time[w] = tbl_time[i];
                        w++;
                    end
                end
                a.removed_any = (w != tbl_count);
                tbl_count = w;
            end
            KIND_LOOKUP: begin
                idx = find_key(r);
                if (idx < tbl_count)
                    a = fill_entry(idx);
            end
            default: begin
                if (tbl_count > 0) begin
                    best = 0;
                    for (int unsigned i = 1; i < tbl_count; i++)
                        if (tbl_load[i] < tbl_load[best])
                            best = i;
                    a = fill_entry(best);
                end
            end
        endcase
        a.entry_count = tbl_count[6:0];
        return a;
    endfunction

    // driver: feeds pending words with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            tx_gap <= 0;
        end else if (s_axis_tvalid && !s_axis_tready) begin
            // hold the offered word
        end else if (tx_gap != 0) begin
            s_axis_tvalid <= 1'b0;
            tx_gap <= tx_gap - 1;
        end else if (pending_words.size() != 0 && (calm || $urandom_range(0, 5) != 0)) begin
            s_axis_tvalid <= 1'b1;
            s_axis_tuser <= pending_words[0].kind;
            s_axis_tdata <= {pending_words[0].time_value, pending_words[0].load,
                             pending_words[0].port, pending_words[0].addr_low,
                             pending_words[0].addr_high};
            expected_answers = {expected_answers, serve_request(pending_words[0])};
            pending_words.delete(0);
            accepted_items <= accepted_items + 1;
        end else begin
            s_axis_tvalid <= 1'b0;
            if (!calm && pending_words.size() != 0)
                tx_gap <= $urandom_range(1, 9);
        end
    end

    // monitor: checks answers against the shadow table and stalls at random
    always @(posedge i_clk) begin
        t_answer got, want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_gap <= 0;
            hold_left <= 0;
            hold_taken <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = take_answer(m_axis_tdata);
                returned_answers <= returned_answers + 1;
                if (expected_answers.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected answer %h", got);
                end else begin
                    want = expected_answers.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: expected %h got %h", want, got);
                    end
                end
            end
            if (hold_left != 0) begin
                m_axis_tready <= 1'b0;
                hold_left <= hold_left - 1;
            end else if (hold_rx && !hold_taken) begin
                m_axis_tready <= 1'b0;
                hold_left <= HOLD_CYCLES;
                hold_taken <= 1'b1;
            end else if (rx_gap != 0) begin
                m_axis_tready <= 1'b0;
                rx_gap <= rx_gap - 1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                rx_gap <= $urandom_range(0, 8);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any transfer
    int unsigned quiet_cycles;
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || hold_left != 0 || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // key pool keeps lookups hitting and lets the table fill
    function automatic t_request pool_request(t_kind k, int unsigned pool);
        t_request r;
        int unsigned n;
        n = $urandom_range(0, pool - 1);
        r.kind = k;
        r.addr_high = (n % 5 == 0) ? {$urandom, $urandom} : {32'hfe80_0000, n[31:0]};
        r.addr_low = (n % 7 == 0) ? 64'hffff_ffff_ffff_ffff : {$urandom, n[31:0]};
        r.addr_low[31:0] = n[31:0];
        r.addr_high[63] = n[0];
        r.port = (n % 3 == 0) ? 16'hffff : 16'(n * 97);
        r.load = ($urandom_range(0, 9) == 0) ? 16'hffff : 16'($urandom);
        r.time_value = 32'd1000 + $urandom_range(0, 60);
        return r;
    endfunction

    task automatic push_word(t_kind k, logic [63:0] ah, logic [63:0] al,
                             logic [15:0] p, logic [15:0] ld, logic [31:0] tv);
        t_request r;
        r.kind = k;
        r.addr_high = ah;
        r.addr_low = al;
        r.port = p;
        r.load = ld;
        r.time_value = tv;
        pending_words = {pending_words, r};
    endtask

    task automatic drain();
        while (pending_words.size() != 0 || s_axis_tvalid || expected_answers.size() != 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_age(logic [31:0] v);
        i_cfg_data <= v;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        age_limit = v;
    endtask

    // random mix: mostly updates and lookups from a key pool
    task automatic random_phase(int unsigned count, int unsigned pool);
        t_request r;
        int unsigned pick;
        for (int unsigned n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                r = pool_request(KIND_UPDATE, pool);
            end else if (pick < 70) begin
                r = pool_request(KIND_LOOKUP, pool);
            end else if (pick < 85) begin
                r = pool_request(KIND_QUERY, pool);
            end else if (pick < 95) begin
                r = pool_request(KIND_EXPIRE, pool);
                r.time_value = 32'd1000 + $urandom_range(0, 90);
            end else begin
                r = t_request'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                                2'($urandom)});
            end
            pending_words = {pending_words, r};
        end
    endtask

    initial begin
        calm = 1'b0;
        hold_rx = 1'b0;
        mismatches = 0;
        accepted_items = 0;
        returned_answers = 0;
        tbl_count = 0;
        age_limit = MaxAgeReset;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, extremes, ties, saturated cutoff
        push_word(KIND_LOOKUP, '1, '1, '1, 16'h0, 32'h0);
        push_word(KIND_QUERY, '0, '0, '0, 16'h0, 32'h0);
        push_word(KIND_EXPIRE, '0, '0, '0, 16'h0, 32'h5);
        push_word(KIND_UPDATE, '1, '1, '1, 16'hffff, 32'hffff_ffff);
        push_word(KIND_UPDATE, '0, '0, '0, 16'h0100, 32'h0);
        push_word(KIND_UPDATE, 64'h1, 64'h2, 16'h3, 16'h0100, 32'd20);
        push_word(KIND_QUERY, '0, '0, '0, 16'h0, 32'h0);
        push_word(KIND_LOOKUP, '1, '1, '1, 16'h0, 32'h0);
        push_word(KIND_LOOKUP, '1, '1, 16'hfffe, 16'h0, 32'h0);
        push_word(KIND_UPDATE, '0, '0, '0, 16'h0000, 32'd15);
        push_word(KIND_QUERY, '0, '0, '0, 16'h0, 32'h0);
        push_word(KIND_EXPIRE, '0, '0, '0, 16'h0, 32'd25);
        push_word(KIND_EXPIRE, '0, '0, '0, 16'h0, 32'hffff_ffff);
        push_word(KIND_QUERY, '0, '0, '0, 16'h0, 32'h0);
        drain();

        // fill the table past full, then a held key and a query
        for (int unsigned i = 0; i < SLOTS + 2; i++)
            push_word(KIND_UPDATE, 64'h2001_0db8, 64'(i), 16'(i), 16'(200 - i), 32'd50);
        push_word(KIND_UPDATE, 64'h2001_0db8, 64'd3, 16'd3, 16'd1, 32'd60);
        push_word(KIND_QUERY, '0, '0, '0, 16'h0, 32'h0);
        drain();
        write_age(32'hffff_ffff);
        push_word(KIND_EXPIRE, '0, '0, '0, 16'h0, 32'hffff_ffff);
        drain();
        write_age(32'd0);
        push_word(KIND_EXPIRE, '0, '0, '0, 16'h0, 32'd55);
        drain();

        // long receiver hold while the sender keeps offering
        write_age(32'd30);
        random_phase(20, 40);
        hold_rx = 1'b1;
        wait (hold_taken && hold_left == 0);
        hold_rx = 1'b0;
        drain();

        for (int unsigned ph = 0; ph < 6; ph++) begin
            write_age(ph[0] ? 32'd20 : 32'(40 + $urandom_range(0, 40)));
            random_phase(280, (ph < 3) ? 48 : 90);
            drain();
        end
        calm = 1'b1;
        random_phase(150, 60);
        drain();

        if (mismatches == 0 && expected_answers.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
`default_nettype wire
